@@ rtl/md4_hash_from_state_unit_assert.svh @@
// Assertion macros shared by the hash engine modules.
// Depends on nothing; the including module must provide clk and rst.
`ifndef MD4_HASH_FROM_STATE_UNIT_ASSERT_SVH
`define MD4_HASH_FROM_STATE_UNIT_ASSERT_SVH

// Checks a consequence in the same cycle as its cause.
`define M4H_ASSERT_SAME(label, cause, effect) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |-> (effect)) \
    else $error("m4h assertion failed");

// Checks a consequence in the cycle after its cause.
`define M4H_ASSERT_NEXT(label, cause, effect) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error("m4h assertion failed");

`endif

@@ rtl/m4h_pkg.sv @@
// Shared types, constants and round functions of the MD4 hash engine.
// Depends on nothing; used by every module of the engine.
package m4h_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [31:0] INIT_A_RESET = 32'h6745_2301;
  localparam logic [31:0] INIT_B_RESET = 32'hEFCD_AB89;
  localparam logic [31:0] INIT_C_RESET = 32'h98BA_DCFE;
  localparam logic [31:0] INIT_D_RESET = 32'h1032_5476;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 60;

  localparam logic [CFG_INDEX_W-1:0] REG_INIT_A      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INIT_B      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INIT_C      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INIT_D      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_BIAS = 3'd4;

  localparam logic [31:0] K_ROUND2 = 32'h5A82_7999;
  localparam logic [31:0] K_ROUND3 = 32'h6ED9_EBA1;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] BLOCK_END  = 6'd63;
  localparam logic [5:0] PAD_END    = 6'd55;   // last zero byte before the length field
  localparam logic [5:0] LAST_ROUND = 6'd47;
  localparam logic [3:0] LEN_LO_WORD = 4'd14;
  localparam logic [3:0] LEN_HI_WORD = 4'd15;
  localparam logic [1:0] LAST_INDEX = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
  } item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_FOLD,
    S_PAD,
    S_LEN,
    S_EMIT
  } state_t;

  // What the sequencer does once a compression has been folded in.
  typedef enum logic [1:0] {
    PH_DATA,
    PH_PAD,
    PH_FINAL
  } phase_t;

  // Message word used by round rnd (0..47).
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [1:0] i;
    logic [1:0] j;
    logic [3:0] k;
    i = rnd[3:2];
    j = rnd[1:0];
    unique case (rnd[5:4])
      2'd0:    k = rnd[3:0];
      2'd1:    k = {j, i};
      default: k = {j[0], j[1], i[0], i[1]};
    endcase
    return k;
  endfunction

  // Left rotation amount of round rnd.
  function automatic logic [4:0] shift_amt(input logic [5:0] rnd);
    logic [4:0] s;
    unique case ({rnd[5:4], rnd[1:0]})
      4'b00_00: s = 5'd3;
      4'b00_01: s = 5'd7;
      4'b00_10: s = 5'd11;
      4'b00_11: s = 5'd19;
      4'b01_00: s = 5'd3;
      4'b01_01: s = 5'd5;
      4'b01_10: s = 5'd9;
      4'b01_11: s = 5'd13;
      4'b10_00: s = 5'd3;
      4'b10_01: s = 5'd9;
      4'b10_10: s = 5'd11;
      default:  s = 5'd15;
    endcase
    return s;
  endfunction

  // One MD4 step: the new value of the target word.
  function automatic logic [31:0] step(input logic [31:0] a, input logic [31:0] b,
                                       input logic [31:0] c, input logic [31:0] d,
                                       input logic [31:0] x, input logic [5:0] rnd);
    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] sum;
    logic [63:0] dbl;
    unique case (rnd[5:4])
      2'd0: begin
        f = (b & c) | (~b & d);
        k = '0;
      end
      2'd1: begin
        f = (b & c) | (b & d) | (c & d);
        k = K_ROUND2;
      end
      default: begin
        f = b ^ c ^ d;
        k = K_ROUND3;
      end
    endcase
    sum = a + f + x + k;
    dbl = {sum, sum} << shift_amt(rnd);
    return dbl[63:32];
  endfunction

endpackage

@@ rtl/m4h_front.sv @@
// Front end of the hash engine: accepts byte items, drops idle ones, queues the rest.
// Depends on m4h_pkg and the assertion macro header.
`include "md4_hash_from_state_unit_assert.svh"

module m4h_front #(
  parameter int QUEUE_DEPTH = m4h_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            byte_valid,
  output logic            byte_stall,
  input  logic [7:0]      data_byte,
  input  logic            has_byte,
  input  logic            last,
  output logic            q_valid,
  output m4h_pkg::item_t  q_item,
  input  logic            q_pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  m4h_pkg::item_t   fifo [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;

  // Items that carry neither a byte nor an end mark change nothing and are dropped here.
  assign byte_stall = (count == CNT_FULL);
  assign push       = byte_valid && !byte_stall && (has_byte || last);
  assign q_valid    = (count != '0);
  assign q_item     = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= '{data: data_byte, has: has_byte, last: last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (q_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `M4H_ASSERT_NEXT(a_push_visible, push, q_valid)
  `M4H_ASSERT_NEXT(a_count_up, push && !q_pop, count == $past(count) + 1'b1)
  `M4H_ASSERT_NEXT(a_count_down, q_pop && !push, count == $past(count) - 1'b1)

endmodule

@@ rtl/m4h_back.sv @@
// Back end of the hash engine: block packing, padding, 48-round compression, digest output.
// Depends on m4h_pkg and the assertion macro header.
`include "md4_hash_from_state_unit_assert.svh"

module m4h_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  m4h_pkg::item_t       q_item,
  output logic                 q_pop,
  input  logic [3:0][31:0]     init_words,
  input  logic [59:0]          length_bias,
  output logic                 digest_valid,
  input  logic                 digest_stall,
  output logic [31:0]          digest_word,
  output logic [1:0]           word_index,
  output logic                 last_word
);

  m4h_pkg::state_t  state;
  m4h_pkg::state_t  state_next;
  m4h_pkg::phase_t  phase;

  logic [3:0][7:0]  blk [16];
  logic [3:0][31:0] chain;
  logic [31:0]      va, vb, vc, vd;
  logic [5:0]       rnd;
  logic [63:0]      byte_count;
  logic             in_message;
  logic [5:0]       pad_pos;
  logic             pad_first;
  logic             item_last;
  logic [1:0]       widx;

  logic [63:0]      cnt_eff;
  logic [5:0]       item_pos;
  logic [63:0]      len_bits;
  logic [31:0]      x_word;
  logic [31:0]      step_out;
  logic             emit_push;
  logic             byte_wr;
  logic [5:0]       byte_wr_pos;
  logic [7:0]       byte_wr_data;
  logic             start_round;

  assign cnt_eff  = in_message ? byte_count : '0;
  assign item_pos = cnt_eff[5:0];
  assign len_bits = (byte_count + {4'b0, length_bias}) << 3;
  assign x_word   = blk[m4h_pkg::msg_index(rnd)];
  assign step_out = m4h_pkg::step(va, vb, vc, vd, x_word, rnd);

  always_comb begin
    state_next = state;
    unique case (state)
      m4h_pkg::S_IDLE: begin
        if (q_valid) begin
          if (q_item.has && item_pos == m4h_pkg::BLOCK_END) begin
            state_next = m4h_pkg::S_ROUND;
          end else if (q_item.last) begin
            state_next = m4h_pkg::S_PAD;
          end
        end
      end
      m4h_pkg::S_ROUND: begin
        if (rnd == m4h_pkg::LAST_ROUND) begin
          state_next = m4h_pkg::S_FOLD;
        end
      end
      m4h_pkg::S_FOLD: begin
        unique case (phase)
          m4h_pkg::PH_DATA:  state_next = item_last ? m4h_pkg::S_PAD : m4h_pkg::S_IDLE;
          m4h_pkg::PH_PAD:   state_next = m4h_pkg::S_PAD;
          default:           state_next = m4h_pkg::S_EMIT;
        endcase
      end
      m4h_pkg::S_PAD: begin
        if (pad_pos == m4h_pkg::BLOCK_END) begin
          state_next = m4h_pkg::S_ROUND;
        end else if (pad_pos == m4h_pkg::PAD_END) begin
          state_next = m4h_pkg::S_LEN;
        end
      end
      m4h_pkg::S_LEN: begin
        state_next = m4h_pkg::S_ROUND;
      end
      m4h_pkg::S_EMIT: begin
        if (emit_push && widx == m4h_pkg::LAST_INDEX) begin
          state_next = m4h_pkg::S_IDLE;
        end
      end
      default: state_next = m4h_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = (state == m4h_pkg::S_IDLE) && q_valid;
    emit_push    = (state == m4h_pkg::S_EMIT) && (!digest_valid || !digest_stall);
    start_round  = (state_next == m4h_pkg::S_ROUND) && (state != m4h_pkg::S_ROUND);
    byte_wr      = 1'b0;
    byte_wr_pos  = pad_pos;
    byte_wr_data = pad_first ? m4h_pkg::PAD_MARK : 8'h00;
    if (q_pop && q_item.has) begin
      byte_wr      = 1'b1;
      byte_wr_pos  = item_pos;
      byte_wr_data = q_item.data;
    end else if (state == m4h_pkg::S_PAD) begin
      byte_wr      = 1'b1;
    end
  end

  // Block store: never cleared, every byte is written before a compression reads it.
  always_ff @(posedge clk) begin
    if (byte_wr) begin
      blk[byte_wr_pos[5:2]][byte_wr_pos[1:0]] <= byte_wr_data;
    end
    if (state == m4h_pkg::S_LEN) begin
      blk[m4h_pkg::LEN_LO_WORD] <= len_bits[31:0];
      blk[m4h_pkg::LEN_HI_WORD] <= len_bits[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (start_round) begin
      va <= chain[0];
      vb <= chain[1];
      vc <= chain[2];
      vd <= chain[3];
    end else if (state == m4h_pkg::S_ROUND) begin
      va <= vd;
      vb <= step_out;
      vc <= vb;
      vd <= vc;
    end
    if (q_pop && !in_message) begin
      chain <= init_words;
    end else if (state == m4h_pkg::S_FOLD) begin
      chain[0] <= chain[0] + va;
      chain[1] <= chain[1] + vb;
      chain[2] <= chain[2] + vc;
      chain[3] <= chain[3] + vd;
    end
    if (emit_push) begin
      digest_word <= chain[widx];
      word_index  <= widx;
      last_word   <= (widx == m4h_pkg::LAST_INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= m4h_pkg::S_IDLE;
      phase        <= m4h_pkg::PH_DATA;
      rnd          <= '0;
      byte_count   <= '0;
      in_message   <= 1'b0;
      pad_pos      <= '0;
      pad_first    <= 1'b0;
      item_last    <= 1'b0;
      widx         <= '0;
      digest_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        in_message <= 1'b1;
        byte_count <= cnt_eff + 64'(q_item.has);
        item_last  <= q_item.last;
        pad_pos    <= item_pos + 6'(q_item.has);
        pad_first  <= 1'b1;
      end
      if (start_round) begin
        rnd <= '0;
        unique case (state)
          m4h_pkg::S_PAD: phase <= m4h_pkg::PH_PAD;
          m4h_pkg::S_LEN: phase <= m4h_pkg::PH_FINAL;
          default:        phase <= m4h_pkg::PH_DATA;
        endcase
      end else if (state == m4h_pkg::S_ROUND) begin
        rnd <= rnd + 1'b1;
      end
      if (state == m4h_pkg::S_FOLD) begin
        pad_pos <= '0;
      end else if (state == m4h_pkg::S_PAD) begin
        pad_pos   <= pad_pos + 1'b1;
        pad_first <= 1'b0;
      end
      if (emit_push) begin
        widx <= widx + 1'b1;
        if (widx == m4h_pkg::LAST_INDEX) begin
          in_message <= 1'b0;
        end
        digest_valid <= 1'b1;
      end else if (!digest_stall) begin
        digest_valid <= 1'b0;
      end
    end
  end

  `M4H_ASSERT_NEXT(a_rounds_end, state == m4h_pkg::S_ROUND && rnd == m4h_pkg::LAST_ROUND,
                   state == m4h_pkg::S_FOLD)
  `M4H_ASSERT_NEXT(a_final_compress, state == m4h_pkg::S_LEN,
                   state == m4h_pkg::S_ROUND && rnd == '0 && phase == m4h_pkg::PH_FINAL)
  `M4H_ASSERT_NEXT(a_digest_done, emit_push && widx == m4h_pkg::LAST_INDEX,
                   state == m4h_pkg::S_IDLE && !in_message && last_word && digest_valid)

endmodule

@@ rtl/md4_hash_from_state_unit.sv @@
// Top level of the MD4 hash engine with a configurable starting state.
// Depends on m4h_pkg, m4h_front and m4h_back.

// The engine hashes a byte stream with MD4, starting from the chaining words held in
// registers 0 to 3 (init_a to init_d, reset to the standard MD4 values) and adding
// register 4 (length_bias, in bytes) to the byte count that goes into the padding
// length field, so a message can continue an earlier hash. Each transfer on the byte
// channel carries one byte (has_byte) and may end the message (last); a transfer with
// neither is ignored. At the end of a message four transfers on the digest channel
// carry words A, B, C and D, with last_word set on D. Accepted items go into a small
// queue (QUEUE_DEPTH entries) in front of the sequencer, so the byte channel keeps
// flowing, until the queue is full, while the sequencer works and while a digest word
// waits to be taken. The sequencer takes one byte per cycle while it is idle; the byte
// that completes a 64-byte block starts a compression (48 rounds through one shared
// step unit, then the fold into the chaining words), during which no byte is taken.
// Ending a message writes the padding one byte per cycle up to byte 56 (up to 64 more
// bytes and one more compression when the last block has no room for the length), then
// the length field, a final compression and the four digest words. The user must see that
// registers are written only while the engine is idle; the block does not enforce it.
module md4_hash_from_state_unit #(
  parameter int QUEUE_DEPTH = m4h_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_en,
  input  logic [m4h_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [m4h_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             byte_valid,
  output logic                             byte_stall,
  input  logic [7:0]                       data_byte,
  input  logic                             has_byte,
  input  logic                             last,
  output logic                             digest_valid,
  input  logic                             digest_stall,
  output logic [31:0]                      digest_word,
  output logic [1:0]                       word_index,
  output logic                             last_word
);

  logic [3:0][31:0] init_words;
  logic [59:0]      length_bias;
  logic             q_valid;
  logic             q_pop;
  m4h_pkg::item_t   q_item;

  // Register writes; an index past the last register is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_words[0] <= m4h_pkg::INIT_A_RESET;
      init_words[1] <= m4h_pkg::INIT_B_RESET;
      init_words[2] <= m4h_pkg::INIT_C_RESET;
      init_words[3] <= m4h_pkg::INIT_D_RESET;
      length_bias   <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        m4h_pkg::REG_INIT_A:      init_words[0] <= cfg_data[31:0];
        m4h_pkg::REG_INIT_B:      init_words[1] <= cfg_data[31:0];
        m4h_pkg::REG_INIT_C:      init_words[2] <= cfg_data[31:0];
        m4h_pkg::REG_INIT_D:      init_words[3] <= cfg_data[31:0];
        m4h_pkg::REG_LENGTH_BIAS: length_bias   <= cfg_data;
        default: ;
      endcase
    end
  end

  // The front end filters and queues items; the back end pops them one at a time.
  m4h_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .data_byte  (data_byte),
    .has_byte   (has_byte),
    .last       (last),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  m4h_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .init_words   (init_words),
    .length_bias  (length_bias),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last_word    (last_word)
  );

endmodule

@@ tb/md4_hash_from_state_unit_test.sv @@
// Self-checking testbench for md4_hash_from_state_unit, the MD4 engine with a settable start.
// Depends on m4h_pkg for the register indexes and port widths, and on the engine itself.
// Expected digests come from an MD4 model in this file that tracks every accepted transfer.
module md4_hash_from_state_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import m4h_pkg::*;

  // Standard MD4 starting words; the engine comes out of reset with these loaded.
  localparam logic [31:0] MD4_IV_A = 32'h6745_2301;
  localparam logic [31:0] MD4_IV_B = 32'hEFCD_AB89;
  localparam logic [31:0] MD4_IV_C = 32'h98BA_DCFE;
  localparam logic [31:0] MD4_IV_D = 32'h1032_5476;
  localparam logic [31:0] MD4_K2   = 32'h5A82_7999;
  localparam logic [31:0] MD4_K3   = 32'h6ED9_EBA1;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [59:0] BIAS_MAX = {60{1'b1}};

  // Register indexes past the last real register; writes to them must be dropped.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int RESET_CYCLES  = 12;
  // Idle margin after the last digest word leaves, before the registers are rewritten.
  localparam int SETTLE_CYCLES = 16;
  // Longest internal path is padding, a spare block and two compressions.
  localparam int TAIL_CYCLES   = 200;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 320;

  typedef struct {
    logic [31:0] word;
    logic [1:0]  index;
    logic        is_last;
  } digest_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                   cfg_write_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;
  logic                   byte_valid   = 1'b0;
  logic                   byte_stall;
  logic [7:0]             data_byte    = '0;
  logic                   has_byte     = 1'b0;
  logic                   last         = 1'b0;
  logic                   digest_valid;
  logic                   digest_stall = 1'b0;
  logic [31:0]            digest_word;
  logic [1:0]             word_index;
  logic                   last_word;

  // Model copy of the configuration registers.
  logic [31:0] start_words [4] = '{MD4_IV_A, MD4_IV_B, MD4_IV_C, MD4_IV_D};
  logic [59:0] length_bias_bytes = '0;

  // Model copy of the hashing state.
  logic [31:0] chain [4];
  logic [31:0] msg_block [16];
  logic [63:0] msg_bytes = '0;
  logic        msg_open = 1'b0;

  // Digest words predicted but not yet seen on the output channel, oldest first.
  digest_entry_t expected_digests [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;
  int words_checked = 0;
  int messages_sent = 0;
  int bytes_sent = 0;
  int work_items = 0;
  int config_sets = 0;
  int cycle_count = 0;

  md4_hash_from_state_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .data_byte    (data_byte),
    .has_byte     (has_byte),
    .last         (last),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last_word    (last_word)
  );

  always #2 clk = ~clk;

  // The run must end well before this; hitting it means the engine hung.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // The digest side holds off at random; the current mix is set by the running test.
  always @(posedge clk) begin
    digest_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // One full 48-step MD4 compression of msg_block into chain.
  function automatic void md4_compress();
    logic [31:0] v [4];
    logic [31:0] b, c, d, f, k, sum;
    int grp, i, j, t, s, w;
    v = chain;
    for (int r = 0; r < 48; r++) begin
      grp = r / 16;
      i = (r / 4) % 4;
      j = r % 4;
      // The target word rotates A, D, C, B within each group of four steps.
      t = (4 - j) % 4;
      b = v[(t + 1) % 4];
      c = v[(t + 2) % 4];
      d = v[(t + 3) % 4];
      case (grp)
        0: begin
          f = (b & c) | (~b & d);
          k = '0;
          w = i * 4 + j;
          s = (j == 0) ? 3 : (j == 1) ? 7 : (j == 2) ? 11 : 19;
        end
        1: begin
          f = (b & c) | (b & d) | (c & d);
          k = MD4_K2;
          w = j * 4 + i;
          s = (j == 0) ? 3 : (j == 1) ? 5 : (j == 2) ? 9 : 13;
        end
        default: begin
          // Third round walks the words in bit-reversed order of j and i.
          f = b ^ c ^ d;
          k = MD4_K3;
          w = (j % 2) * 8 + (j / 2) * 4 + (i % 2) * 2 + (i / 2);
          s = (j == 0) ? 3 : (j == 1) ? 9 : (j == 2) ? 11 : 15;
        end
      endcase
      sum = v[t] + f + msg_block[w] + k;
      v[t] = (sum << s) | (sum >> (32 - s));
    end
    for (int q = 0; q < 4; q++) chain[q] += v[q];
  endfunction

  // Applies one accepted byte-channel transfer to the model and queues any digest words.
  function automatic void md4_absorb_item(input logic [7:0] value, input logic has,
                                          input logic ends_msg);
    int p;
    logic [63:0] bit_len;
    digest_entry_t e;
    if (!has && !ends_msg) return;
    if (!msg_open) begin
      chain = start_words;
      msg_bytes = '0;
      msg_open = 1'b1;
    end
    if (has) begin
      p = int'(msg_bytes[5:0]);
      msg_block[p / 4][8 * (p % 4) +: 8] = value;
      msg_bytes++;
      if (p == 63) md4_compress();
    end
    if (!ends_msg) return;
    p = int'(msg_bytes[5:0]);
    msg_block[p / 4][8 * (p % 4) +: 8] = PAD_BYTE;
    for (int z = p + 1; z < 64; z++) msg_block[z / 4][8 * (z % 4) +: 8] = 8'h00;
    // With the marker at byte 56 or later the length needs a block of its own.
    if (p >= 56) begin
      md4_compress();
      for (int z = 0; z < 14; z++) msg_block[z] = '0;
    end
    bit_len = (msg_bytes + 64'(length_bias_bytes)) << 3;
    msg_block[14] = bit_len[31:0];
    msg_block[15] = bit_len[63:32];
    md4_compress();
    for (int q = 0; q < 4; q++) begin
      e.word = chain[q];
      e.index = 2'(q);
      e.is_last = (q == 3);
      expected_digests.push_back(e);
    end
    msg_open = 1'b0;
  endfunction

  // Every digest transfer is matched against the oldest prediction, field by field.
  always @(posedge clk) begin
    digest_entry_t want;
    if (!rst && digest_valid && !digest_stall) begin
      words_checked <= words_checked + 1;
      if (expected_digests.size() == 0) begin
        $display("%0t: digest transfer with none expected: word %h index %0d last %b",
                 $time, digest_word, word_index, last_word);
        fail_count++;
      end else begin
        want = expected_digests.pop_front();
        if (digest_word !== want.word) begin
          $display("%0t: digest_word expected %h, got %h", $time, want.word, digest_word);
          fail_count++;
        end
        if (word_index !== want.index) begin
          $display("%0t: word_index expected %0d, got %0d", $time, want.index, word_index);
          fail_count++;
        end
        if (last_word !== want.is_last) begin
          $display("%0t: last_word expected %b, got %b", $time, want.is_last, last_word);
          fail_count++;
        end
      end
    end
  end

  // Offers one item on the byte channel and returns at the edge where it is taken.
  // Valid stays high on return so back-to-back items never drop it within a time step;
  // whoever waits afterwards lowers it first.
  task automatic send_item(input logic [7:0] value, input logic has, input logic ends_msg);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte <= value;
    has_byte <= has;
    last <= ends_msg;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    md4_absorb_item(value, has, ends_msg);
    if (has || ends_msg) work_items++;
    if (has) bytes_sent++;
    if (ends_msg) messages_sent++;
  endtask

  // Sends a message of random bytes with ignored transfers sprinkled in. The end mark
  // rides on the final byte, or on an empty transfer of its own when asked or when empty.
  task automatic send_message(input int len, input bit separate_end, input int noise_pct);
    for (int n = 0; n < len; n++) begin
      while ($urandom_range(99) < noise_pct) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, (n == len - 1) && !separate_end);
    end
    if (len == 0 || separate_end) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // Stops offering bytes and waits until every predicted digest word has been taken.
  // At least one edge passes, so back-to-back calls never drive valid twice in a step.
  task automatic wait_for_digests();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (expected_digests.size() != 0) @(posedge clk);
  endtask

  // Writes one register; the enable is left high for a following write.
  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_INIT_A:      start_words[0] = value[31:0];
      REG_INIT_B:      start_words[1] = value[31:0];
      REG_INIT_C:      start_words[2] = value[31:0];
      REG_INIT_D:      start_words[3] = value[31:0];
      REG_LENGTH_BIAS: length_bias_bytes = value;
      default: ;
    endcase
  endtask

  // Reprograms all registers once the engine is idle. Init words carry junk above bit 31,
  // which the engine must drop, and a write to a spare index must change nothing.
  task automatic load_config(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c,
                             input logic [31:0] d, input logic [59:0] bias);
    wait_for_digests();
    repeat (SETTLE_CYCLES) @(posedge clk);
    put_reg(REG_INIT_A, {28'($urandom), a});
    put_reg(REG_INIT_B, {28'($urandom), b});
    put_reg(REG_INIT_C, {28'($urandom), c});
    put_reg(REG_INIT_D, {28'($urandom), d});
    put_reg(REG_LENGTH_BIAS, bias);
    put_reg(CFG_INDEX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)),
            60'({$urandom, $urandom}));
    cfg_write_en <= 1'b0;
    config_sets++;
  endtask

  // Short hand-picked messages on the reset configuration.
  task automatic test_short_messages();
    send_item(8'h5A, 1'b0, 1'b0);      // ignored before any message has begun
    send_item(8'hFF, 1'b0, 1'b1);      // empty message; the data bits must be ignored
    send_item(8'h00, 1'b0, 1'b1);      // a second empty message right behind it
    send_item(8'h00, 1'b1, 1'b1);      // one byte, end mark on the same transfer
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b0);      // ignored in the middle of a message
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'h3C, 1'b0, 1'b1);      // end mark on its own transfer
  endtask

  // Lengths where the padding just fits, just misses, or the last byte fills a block.
  task automatic test_block_boundaries();
    send_message(55, 1'b0, 0);
    send_message(56, 1'b0, 0);
    send_message(63, 1'b1, 5);
    send_message(64, 1'b0, 0);
    send_message(64, 1'b1, 0);
  endtask

  // Extreme and random starting states and length bias, then back to the defaults.
  task automatic test_config_extremes();
    load_config('0, '0, '0, '0, '0);
    send_message(5, 1'b0, 10);
    send_message(0, 1'b1, 0);
    // Full bias with one byte drives the length field into its top bit.
    load_config('1, '1, '1, '1, BIAS_MAX);
    send_message(1, 1'b0, 0);
    send_message(0, 1'b1, 0);
    send_message(64, 1'b0, 0);
    load_config($urandom, $urandom, $urandom, $urandom, 60'({$urandom, $urandom}));
    send_message(20, 1'b1, 10);
    load_config(MD4_IV_A, MD4_IV_B, MD4_IV_C, MD4_IV_D, '0);
  endtask

  // Random messages, mostly short, with occasional long ones and block-edge lengths.
  task automatic test_random_traffic();
    int goal;
    int len;
    int pick;
    for (int mix = 0; mix < 3; mix++) begin
      // Sender busy and digest side slow, then the reverse, then no idling at all.
      case (mix)
        0: begin
          send_idle_pct = 22;
          recv_idle_pct = 71;
        end
        1: begin
          wait_for_digests();
          send_idle_pct = 71;
          recv_idle_pct = 22;
          load_config($urandom, $urandom, $urandom, $urandom, 60'($urandom_range(1, 4096)));
        end
        default: begin
          wait_for_digests();
          send_idle_pct = 0;
          recv_idle_pct = 0;
          load_config(MD4_IV_A, MD4_IV_B, MD4_IV_C, MD4_IV_D, '0);
        end
      endcase
      goal = work_items + RANDOM_ITEMS / 3;
      while (work_items < goal) begin
        pick = $urandom_range(99);
        if (pick < 60) len = $urandom_range(12);
        else if (pick < 85) len = $urandom_range(40, 13);
        else begin
          case ($urandom_range(5))
            0: len = 55;
            1: len = 56;
            2: len = 63;
            3: len = 64;
            4: len = 119;
            default: len = 128;
          endcase
        end
        send_message(len, $urandom_range(3) == 0, 8);
        // Now and then let the engine run completely dry before the next message.
        if ($urandom_range(5) == 0) wait_for_digests();
      end
    end
  endtask

  initial begin
    send_idle_pct = 22;
    recv_idle_pct = 71;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_short_messages();
    test_block_boundaries();
    test_config_extremes();
    test_random_traffic();
    wait_for_digests();
    // Keep watching for a while so that a stray extra digest word is caught.
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Hashed %0d messages (%0d bytes) over %0d register settings and three idle mixes;",
             messages_sent, bytes_sent, config_sets);
    $display("%0d digest words were compared with the model.", words_checked);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
